// ===== hw/rtl/psq_pkg.sv =====
// Shared constants, types and the scale search function of the pitch quantizer.
package psq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PITCH_W   = 21;
  localparam int OFFS_W    = 18;
  localparam int MASK_W    = 12;
  localparam int NOTE_W    = 9;
  localparam int CLASS_W   = 4;
  localparam int CFG_IDX_W = 1;

  localparam int SUM_W  = PITCH_W + 1;
  localparam int PROD_W = SUM_W + 5;
  localparam int BIN_W  = PROD_W - FRAC_BITS;
  localparam int OCT_W  = 8;
  localparam int IDX_W  = 5;
  localparam int NN_W   = 7;
  localparam int RAW_W  = 12;
  localparam int SEMIS  = 12;

  // Floor division of the bin by 24: bias to a non-negative multiple of 24,
  // multiply by a reciprocal, then remove the bias again.
  localparam int DIV_U_W   = 12;
  localparam int DIV_BIAS  = 1032;
  localparam int DIV_OCT   = DIV_BIAS / 24;
  localparam int DIV_RECIP = 2731;
  localparam int DIV_SHIFT = 16;
  localparam int DIV_Q_W   = 7;

  localparam int NOTE_MAX      = 160;
  localparam int MAG_W         = 8;
  localparam int CLASS_AT_MAX  = NOTE_MAX % SEMIS;
  localparam int CLASS_AT_MIN  = SEMIS - CLASS_AT_MAX;

  // Rounded volts: (mag * 2^FRAC_BITS + 6) / 12 by reciprocal multiplication.
  localparam int NUM_W     = FRAC_BITS + MAG_W;
  localparam int VDIV_SH   = NUM_W + 4;
  localparam longint VDIV_RECIP = ((64'd1 << VDIV_SH) + 64'd11) / 64'd12;
  localparam int VREC_W    = NUM_W + 1;
  localparam int VPROD_W   = NUM_W + VREC_W;
  localparam int QMAG_W    = PITCH_W - 1;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MASK   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFFSET = 1'b1;

  typedef struct packed {
    logic                    valid;
    logic signed [OCT_W-1:0] octave;
    logic [IDX_W-1:0]        idx;
  } bin_t;

  typedef struct packed {
    logic                     valid;
    logic signed [NOTE_W-1:0] note;
    logic [CLASS_W-1:0]       pclass;
  } note_t;

  function automatic logic note_enabled(logic signed [NN_W-1:0] n,
                                        logic [MASK_W-1:0] mask);
    logic signed [NN_W-1:0] pc;
    if (n < 0) begin
      pc = n + NN_W'(SEMIS);
    end else if (n >= NN_W'(SEMIS)) begin
      pc = n - NN_W'(SEMIS);
    end else begin
      pc = n;
    end
    return (mask == '0) || mask[pc[CLASS_W-1:0]];
  endfunction

  // Nearest enabled note to (idx + 1) >> 1. Any nonempty 12-note mask has an
  // enabled note within six semitones, so the search stops there. Scanning
  // from far to near, lower after upper, lets the lower note win a tie.
  function automatic logic signed [NN_W-1:0] nearest_note(logic [IDX_W-1:0] idx,
                                                          logic [MASK_W-1:0] mask);
    logic [IDX_W-1:0]       inc;
    logic signed [NN_W-1:0] tgt;
    logic signed [NN_W-1:0] cand;
    logic signed [NN_W-1:0] best;
    inc  = idx + IDX_W'(1);
    tgt  = $signed({3'b000, inc[IDX_W-1:1]});
    best = '0;
    for (int d = 6; d >= 0; d--) begin
      cand = tgt + NN_W'(d);
      if (note_enabled(cand, mask)) begin
        best = cand;
      end
      cand = tgt - NN_W'(d);
      if (note_enabled(cand, mask)) begin
        best = cand;
      end
    end
    return best;
  endfunction

endpackage

// ===== hw/rtl/psq_bin.sv =====
// Offset add, half-semitone binning and split into octave and bin index.
module psq_bin (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             valid,
  input  logic signed [psq_pkg::PITCH_W-1:0] pitch,
  input  logic signed [psq_pkg::OFFS_W-1:0]  offset,
  output psq_pkg::bin_t                    bin_o
);

  logic signed [psq_pkg::SUM_W-1:0]  sum;
  logic signed [psq_pkg::PROD_W-1:0] sum_x;
  logic signed [psq_pkg::PROD_W-1:0] prod;
  logic                              bvalid_r;
  logic signed [psq_pkg::BIN_W-1:0]  bin_r;
  logic [psq_pkg::DIV_U_W-1:0]       u;
  logic [2*psq_pkg::DIV_U_W-1:0]     q_full;
  logic [psq_pkg::DIV_Q_W-1:0]       q;
  logic [psq_pkg::DIV_U_W-1:0]       rem;
  psq_pkg::bin_t                     bin_nxt;
  psq_pkg::bin_t                     bin_o_r;

  assign sum   = psq_pkg::SUM_W'(pitch) + psq_pkg::SUM_W'(offset);
  assign sum_x = psq_pkg::PROD_W'(sum);
  // (pitch + offset) * 24; dropping the fraction bits of a two's complement value floors.
  assign prod  = (sum_x <<< 4) + (sum_x <<< 3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= 1'b0;
    end else begin
      bvalid_r <= valid;
    end
    bin_r <= prod[psq_pkg::PROD_W-1:psq_pkg::FRAC_BITS];
  end

  assign u      = psq_pkg::DIV_U_W'(psq_pkg::DIV_U_W'(bin_r) + psq_pkg::DIV_U_W'(psq_pkg::DIV_BIAS));
  assign q_full = {{psq_pkg::DIV_U_W{1'b0}}, u} * (2*psq_pkg::DIV_U_W)'(psq_pkg::DIV_RECIP);
  assign q      = q_full[psq_pkg::DIV_SHIFT +: psq_pkg::DIV_Q_W];
  assign rem    = u - psq_pkg::DIV_U_W'({q, 4'b0000} + {q, 3'b000});

  always_comb begin
    bin_nxt.valid  = bvalid_r;
    bin_nxt.octave = $signed(psq_pkg::OCT_W'(q)) - psq_pkg::OCT_W'(psq_pkg::DIV_OCT);
    bin_nxt.idx    = rem[psq_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_o_r.valid <= 1'b0;
    end else begin
      bin_o_r.valid <= bin_nxt.valid;
    end
    bin_o_r.octave <= bin_nxt.octave;
    bin_o_r.idx    <= bin_nxt.idx;
  end

  assign bin_o = bin_o_r;

endmodule

// ===== hw/rtl/psq_snap.sv =====
// Scale lookup, octave recombination, saturation and pitch class.
module psq_snap (
  input  logic                          clk,
  input  logic                          rst_n,
  input  psq_pkg::bin_t                 bin_i,
  input  logic [psq_pkg::MASK_W-1:0]    mask,
  output psq_pkg::note_t                note_o
);

  logic signed [psq_pkg::NN_W-1:0]  nn;
  logic signed [psq_pkg::RAW_W-1:0] oct_x;
  logic signed [psq_pkg::RAW_W-1:0] raw;
  logic [psq_pkg::CLASS_W-1:0]      nn_class;
  psq_pkg::note_t                   note_nxt;
  psq_pkg::note_t                   note_r;

  assign nn    = psq_pkg::nearest_note(bin_i.idx, mask);
  assign oct_x = psq_pkg::RAW_W'(bin_i.octave);
  assign raw   = psq_pkg::RAW_W'(nn) + (oct_x <<< 3) + (oct_x <<< 2);

  always_comb begin
    if (nn < 0) begin
      nn_class = psq_pkg::CLASS_W'(nn + psq_pkg::NN_W'(psq_pkg::SEMIS));
    end else if (nn >= psq_pkg::NN_W'(psq_pkg::SEMIS)) begin
      nn_class = psq_pkg::CLASS_W'(nn - psq_pkg::NN_W'(psq_pkg::SEMIS));
    end else begin
      nn_class = psq_pkg::CLASS_W'(nn);
    end
  end

  always_comb begin
    note_nxt.valid = bin_i.valid;
    if (raw > psq_pkg::RAW_W'(psq_pkg::NOTE_MAX)) begin
      note_nxt.note   = psq_pkg::NOTE_W'(psq_pkg::NOTE_MAX);
      note_nxt.pclass = psq_pkg::CLASS_W'(psq_pkg::CLASS_AT_MAX);
    end else if (raw < -psq_pkg::RAW_W'(psq_pkg::NOTE_MAX)) begin
      note_nxt.note   = -psq_pkg::NOTE_W'(psq_pkg::NOTE_MAX);
      note_nxt.pclass = psq_pkg::CLASS_W'(psq_pkg::CLASS_AT_MIN);
    end else begin
      note_nxt.note   = raw[psq_pkg::NOTE_W-1:0];
      note_nxt.pclass = nn_class;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_r.valid <= 1'b0;
    end else begin
      note_r.valid <= note_nxt.valid;
    end
    note_r.note   <= note_nxt.note;
    note_r.pclass <= note_nxt.pclass;
  end

  assign note_o = note_r;

endmodule

// ===== hw/rtl/psq_volts.sv =====
// Conversion of the quantized note back to volts, plus the result register.
module psq_volts (
  input  logic                               clk,
  input  logic                               rst_n,
  input  psq_pkg::note_t                     note_i,
  output logic                               valid_o,
  output logic signed [psq_pkg::NOTE_W-1:0]  note_o,
  output logic signed [psq_pkg::PITCH_W-1:0] volts_o,
  output logic [psq_pkg::CLASS_W-1:0]        pclass_o
);

  logic [psq_pkg::MAG_W-1:0]           mag;
  logic [psq_pkg::NUM_W-1:0]           num;
  logic [psq_pkg::VPROD_W-1:0]         prod;
  psq_pkg::note_t                      hold_r;
  logic [psq_pkg::QMAG_W-1:0]          qmag_r;
  logic                                valid_r;
  logic signed [psq_pkg::NOTE_W-1:0]   note_r;
  logic signed [psq_pkg::PITCH_W-1:0]  volts_r;
  logic signed [psq_pkg::PITCH_W-1:0]  volts_nxt;
  logic [psq_pkg::CLASS_W-1:0]         pclass_r;

  assign mag  = note_i.note[psq_pkg::NOTE_W-1]
              ? psq_pkg::MAG_W'(-note_i.note) : psq_pkg::MAG_W'(note_i.note);
  assign num  = {mag, {psq_pkg::FRAC_BITS{1'b0}}} + psq_pkg::NUM_W'(6);
  assign prod = psq_pkg::VPROD_W'(num) * psq_pkg::VPROD_W'(psq_pkg::VDIV_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r.valid <= 1'b0;
    end else begin
      hold_r.valid <= note_i.valid;
    end
    hold_r.note   <= note_i.note;
    hold_r.pclass <= note_i.pclass;
    qmag_r        <= prod[psq_pkg::VDIV_SH +: psq_pkg::QMAG_W];
  end

  assign volts_nxt = hold_r.note[psq_pkg::NOTE_W-1]
                   ? -$signed({1'b0, qmag_r}) : $signed({1'b0, qmag_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= hold_r.valid;
    end
    note_r   <= hold_r.note;
    volts_r  <= volts_nxt;
    pclass_r <= hold_r.pclass;
  end

  assign valid_o  = valid_r;
  assign note_o   = note_r;
  assign volts_o  = volts_r;
  assign pclass_o = pclass_r;

endmodule

// ===== hw/rtl/pitch_scale_quantizer.sv =====
// Top level of the pitch quantizer: configuration, input register and pipeline.
//
// A request is taken on every cycle that start is high; busy is always low.
// Each request gives exactly one result, shown for one cycle with out_valid
// high, after it passes the input register, bin register, octave split,
// scale lookup, reciprocal multiply for the volts value and result register.
// Throughput is one request per clock, set by the six-stage pipeline; the
// receiver cannot stall it, so results must be captured when they appear.
// The user is to write scale_mask and pitch_offset through the cfg port only
// while no request is in flight; the block itself does not enforce this.
module pitch_scale_quantizer (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [psq_pkg::PITCH_W-1:0]     in_pitch_in,
  input  logic                                   cfg_we,
  input  logic [psq_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [psq_pkg::OFFS_W-1:0]             cfg_data,
  output logic                                   out_valid,
  output logic signed [psq_pkg::NOTE_W-1:0]      out_note_number,
  output logic signed [psq_pkg::PITCH_W-1:0]     out_pitch_out,
  output logic [psq_pkg::CLASS_W-1:0]            out_pitch_class
);

  logic [psq_pkg::MASK_W-1:0]          scale_mask_r;
  logic signed [psq_pkg::OFFS_W-1:0]   pitch_offset_r;
  logic                                in_valid_r;
  logic signed [psq_pkg::PITCH_W-1:0]  in_pitch_r;
  psq_pkg::bin_t                       bin_s;
  psq_pkg::note_t                      note_s;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mask_r   <= '1;
      pitch_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        psq_pkg::REG_SCALE_MASK:   scale_mask_r   <= cfg_data[psq_pkg::MASK_W-1:0];
        psq_pkg::REG_PITCH_OFFSET: pitch_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
    in_pitch_r <= in_pitch_in;
  end

  psq_bin u_bin (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid  (in_valid_r),
    .pitch  (in_pitch_r),
    .offset (pitch_offset_r),
    .bin_o  (bin_s)
  );

  psq_snap u_snap (
    .clk    (clk),
    .rst_n  (rst_n),
    .bin_i  (bin_s),
    .mask   (scale_mask_r),
    .note_o (note_s)
  );

  psq_volts u_volts (
    .clk      (clk),
    .rst_n    (rst_n),
    .note_i   (note_s),
    .valid_o  (out_valid),
    .note_o   (out_note_number),
    .volts_o  (out_pitch_out),
    .pclass_o (out_pitch_class)
  );

  // Every result comes from a matching request taken earlier.
  a_out_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 6))
    else $error("result without a matching request");

  a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_note_number <= psq_pkg::NOTE_W'(psq_pkg::NOTE_MAX)) &&
                  (out_note_number >= -psq_pkg::NOTE_W'(psq_pkg::NOTE_MAX)))
    else $error("note number outside saturation range");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_class < psq_pkg::CLASS_W'(psq_pkg::SEMIS))
    else $error("pitch class out of range");

  // Volts and note must agree in sign, and zero maps to zero.
  a_volts_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_note_number < 0) == (out_pitch_out < 0)) &&
                  ((out_note_number == 0) == (out_pitch_out == 0)))
    else $error("pitch_out sign does not match note number");

endmodule
